### hdl/rwl_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// rwl_pkg: shared types and constants of the reader-writer lock manager
// Request and response payloads, the job record between the front and back
// parts, the queue write record and the state type of the back part.
// ============================================================================
package rwl_pkg;

	localparam int ID_W       = 8;
	localparam int RC_W       = 16;
	localparam int PEAK_W     = 5;
	localparam int JQ_DEPTH   = 2;
	localparam int JQ_AW      = $clog2(JQ_DEPTH);
	localparam int JQ_CW      = $clog2(JQ_DEPTH + 1);

	localparam logic [RC_W-1:0] READER_MAX = {RC_W{1'b1}};

	typedef enum logic [1:0] {
		CMD_EXCL   = 2'd0,
		CMD_SHARED = 2'd1,
		CMD_UNLOCK = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		KIND_GRANTED  = 3'd0,
		KIND_QUEUED   = 3'd1,
		KIND_RELEASED = 3'd2,
		KIND_WOKEN    = 3'd3,
		KIND_BAD      = 3'd4,
		KIND_FULL     = 3'd5
	} kind_t;

	typedef struct packed {
		cmd_t            cmd;
		logic [ID_W-1:0] requester;
	} req_t;

	typedef struct packed {
		kind_t             kind;
		logic [ID_W-1:0]   who;
		logic              from_shared_queue;
		logic              last;
		logic [PEAK_W-1:0] peak_shared_waiting;
		logic [PEAK_W-1:0] peak_exclusive_waiting;
	} rsp_t;

	// One classified request: its head result plus the wake work behind it.
	typedef struct packed {
		kind_t             kind;
		logic [ID_W-1:0]   who;
		logic              shared_first;
		logic [PEAK_W-1:0] n_shared;
		logic [PEAK_W-1:0] n_excl;
		logic [PEAK_W-1:0] peak_shared;
		logic [PEAK_W-1:0] peak_excl;
	} job_t;

	// Write into one of the wait queues.
	typedef struct packed {
		logic            valid;
		logic            to_shared;
		logic [ID_W-1:0] id;
	} qpush_t;

	typedef enum logic {
		BK_IDLE  = 1'b0,
		BK_DRAIN = 1'b1
	} back_state_t;

endpackage

### hdl/reader_writer_lock_manager_top.sv
`timescale 1ns / 1ps
// ============================================================================
// reader_writer_lock_manager_top: reader-writer lock manager
// Exclusive and shared lock requests with two FIFO wait queues.
// ============================================================================
// Usage:
// Requests arrive on req (cmd, requester) under req_valid / req_stall and
// responses leave on rsp under rsp_valid / rsp_stall. A transfer happens on
// a rising edge where valid is high and stall is low.
// Every request except the unused command code yields at least one response;
// the final response of a request carries last = 1.
// With the block idle, the first response of a request passes through the job
// queue and the response register before it is valid on rsp. Lock requests
// and unlocks with empty queues sustain one request per cycle while rsp_stall
// is low. An unlock that finds waiters produces one response per cycle while
// rsp_stall is low, the release followed by one woken response per waiter from
// the drain sequencer; req_stall stays high until the last waiter is out.
// A two-entry job queue lets the front keep taking requests while the back
// part waits on a stalled output register; when it fills, req_stall rises.
// When the receiver stalls, the response register holds its value and the
// back part pauses; nothing is lost.
// Reset clears the owner, reader count, fill counts, peaks, pointers, flags
// and back state at once; drain registers and queue storage need no clearing.
// ============================================================================
module reader_writer_lock_manager_top import rwl_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	// Front to job queue.
	logic   job_push, job_full;
	job_t   job_in;

	// Job queue to back.
	logic   job_valid, job_pop;
	job_t   job_out;

	// Queue writes from the front land in the back part's storage, and the
	// back part tells the front when a drain has emptied the queues.
	qpush_t qpush;
	logic   drain_done;

	rwl_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.job_push   (job_push),
		.job        (job_in),
		.job_full   (job_full),
		.drain_done (drain_done),
		.qpush      (qpush)
	);

	rwl_jobq u_jobq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_job  (job_in),
		.full      (job_full),
		.pop_valid (job_valid),
		.pop_job   (job_out),
		.pop       (job_pop)
	);

	rwl_back #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (job_valid),
		.job        (job_out),
		.job_pop    (job_pop),
		.qpush      (qpush),
		.drain_done (drain_done),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp)
	);

endmodule

### hdl/rwl_front.sv
`timescale 1ns / 1ps
// ============================================================================
// rwl_front: request classification and lock state
// Accepts requests, decides grant, queue, release or error, keeps owner,
// reader count, queue fill counts and peaks; posts one job per known command.
// ============================================================================
module rwl_front import rwl_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   req_valid,
	output logic   req_stall,
	input  req_t   req,
	output logic   job_push,
	output job_t   job,
	input  logic   job_full,
	input  logic   drain_done,
	output qpush_t qpush
);

	localparam int FW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [FW-1:0] FILL_MAX = FW'(QUEUE_DEPTH);

	logic            owner_held_q, owner_held_d;
	logic [ID_W-1:0] owner_id_q, owner_id_d;
	logic [RC_W-1:0] rc_q, rc_d;
	logic [FW-1:0]   sh_fill_q, sh_fill_d, ex_fill_q, ex_fill_d;
	logic [FW-1:0]   pk_sh_q, pk_sh_d, pk_ex_q, pk_ex_d;
	logic            drain_pend_q, drain_pend_d;
	logic            accept;

	// While the back part drains the queues, no new request may touch them.
	assign req_stall = drain_pend_q || job_full;
	assign accept    = req_valid && !req_stall;

	always_comb begin
		owner_held_d = owner_held_q;
		owner_id_d   = owner_id_q;
		rc_d         = rc_q;
		sh_fill_d    = sh_fill_q;
		ex_fill_d    = ex_fill_q;
		pk_sh_d      = pk_sh_q;
		pk_ex_d      = pk_ex_q;
		drain_pend_d = drain_pend_q && !drain_done;
		job_push     = 1'b0;
		qpush        = '0;
		job          = '0;
		job.who      = req.requester;
		job.kind     = KIND_FULL;
		if (accept) begin
			job_push = 1'b1;
			unique case (req.cmd)
				CMD_EXCL: begin
					if (!owner_held_q && rc_q == '0) begin
						owner_held_d = 1'b1;
						owner_id_d   = req.requester;
						job.kind     = KIND_GRANTED;
					end else if (ex_fill_q < FILL_MAX) begin
						qpush.valid     = 1'b1;
						qpush.to_shared = 1'b0;
						qpush.id        = req.requester;
						ex_fill_d       = ex_fill_q + 1'b1;
						if (ex_fill_d > pk_ex_q) begin
							pk_ex_d = ex_fill_d;
						end
						job.kind = KIND_QUEUED;
					end
				end
				CMD_SHARED: begin
					if (!owner_held_q) begin
						if (rc_q != READER_MAX) begin
							rc_d     = rc_q + 1'b1;
							job.kind = KIND_GRANTED;
						end
					end else if (sh_fill_q < FILL_MAX) begin
						qpush.valid     = 1'b1;
						qpush.to_shared = 1'b1;
						qpush.id        = req.requester;
						sh_fill_d       = sh_fill_q + 1'b1;
						if (sh_fill_d > pk_sh_q) begin
							pk_sh_d = sh_fill_d;
						end
						job.kind = KIND_QUEUED;
					end
				end
				CMD_UNLOCK: begin
					if (rc_q == '0 && (!owner_held_q || owner_id_q != req.requester)) begin
						job.kind = KIND_BAD;
					end else begin
						if (rc_q == '0) begin
							owner_held_d     = 1'b0;
							owner_id_d       = '0;
							job.shared_first = 1'b1;
						end else begin
							rc_d             = rc_q - 1'b1;
							job.shared_first = (rc_d != '0);
						end
						job.kind     = KIND_RELEASED;
						job.n_shared = PEAK_W'(sh_fill_q);
						job.n_excl   = PEAK_W'(ex_fill_q);
						sh_fill_d    = '0;
						ex_fill_d    = '0;
						drain_pend_d = (sh_fill_q != '0) || (ex_fill_q != '0);
					end
				end
				default: begin
					job_push = 1'b0;
				end
			endcase
		end
		job.peak_shared = PEAK_W'(pk_sh_d);
		job.peak_excl   = PEAK_W'(pk_ex_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_held_q <= 1'b0;
			owner_id_q   <= '0;
			rc_q         <= '0;
			sh_fill_q    <= '0;
			ex_fill_q    <= '0;
			pk_sh_q      <= '0;
			pk_ex_q      <= '0;
			drain_pend_q <= 1'b0;
		end else begin
			owner_held_q <= owner_held_d;
			owner_id_q   <= owner_id_d;
			rc_q         <= rc_d;
			sh_fill_q    <= sh_fill_d;
			ex_fill_q    <= ex_fill_d;
			pk_sh_q      <= pk_sh_d;
			pk_ex_q      <= pk_ex_d;
			drain_pend_q <= drain_pend_d;
		end
	end

`ifndef SYNTH
	// Readers and an exclusive owner never hold the lock together.
	a_owner_xor_readers: assert property (@(posedge clk) disable iff (!arst_n)
		!(owner_held_q && rc_q != '0))
		else $error("owner and readers hold the lock together");

	// A request is never taken while a drain is outstanding.
	a_no_accept_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		drain_pend_q |-> !accept)
		else $error("request accepted during drain");

	// Peaks never fall below the live fill counts.
	a_peak_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(pk_sh_q >= sh_fill_q) && (pk_ex_q >= ex_fill_q))
		else $error("peak below fill");
`endif

endmodule

### hdl/rwl_jobq.sv
`timescale 1ns / 1ps
// ============================================================================
// rwl_jobq: short job queue between the front and back parts
// A two-entry register FIFO of classified jobs.
// ============================================================================
module rwl_jobq import rwl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	output logic pop_valid,
	output job_t pop_job,
	input  logic pop
);

	job_t             mem_q [JQ_DEPTH];
	logic [JQ_AW-1:0] wr_q, rd_q;
	logic [JQ_CW-1:0] cnt_q;

	assign full      = (cnt_q == JQ_CW'(JQ_DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_job   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == JQ_AW'(JQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == JQ_AW'(JQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + JQ_CW'(push) - JQ_CW'(pop);
		end
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= JQ_CW'(JQ_DEPTH))
		else $error("job queue overflow");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> pop_valid)
		else $error("job queue popped while empty");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job queue pushed while full");
`endif

endmodule

### hdl/rwl_back.sv
`timescale 1ns / 1ps
// ============================================================================
// rwl_back: result generation and wait queue drain
// Holds both wait queues, turns each job into its head result and then wakes
// queued waiters one per cycle, unless stalled, into the response register.
// ============================================================================
module rwl_back import rwl_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   job_valid,
	input  job_t   job,
	output logic   job_pop,
	input  qpush_t qpush,
	output logic   drain_done,
	output logic   rsp_valid,
	input  logic   rsp_stall,
	output rsp_t   rsp
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	logic [ID_W-1:0]   sq_mem_q [QUEUE_DEPTH];
	logic [ID_W-1:0]   eq_mem_q [QUEUE_DEPTH];
	logic [PW-1:0]     sq_head_q, sq_tail_q, eq_head_q, eq_tail_q;
	back_state_t       state_q, state_d;
	logic [PEAK_W-1:0] rem_s_q, rem_s_d, rem_e_q, rem_e_d;
	logic              shared_first_q, shared_first_d;
	logic [PEAK_W-1:0] pk_s_q, pk_s_d, pk_e_q, pk_e_d;
	logic              rsp_valid_q;
	rsp_t              rsp_q, rsp_d;
	logic              load, load_ok, use_s, sq_pop, eq_pop;
	logic [PEAK_W:0]   rem_total;

	assign load_ok   = !rsp_valid_q || !rsp_stall;
	assign rem_total = {1'b0, rem_s_q} + {1'b0, rem_e_q};
	assign use_s     = shared_first_q ? (rem_s_q != '0) : (rem_e_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		rem_s_d        = rem_s_q;
		rem_e_d        = rem_e_q;
		shared_first_d = shared_first_q;
		pk_s_d         = pk_s_q;
		pk_e_d         = pk_e_q;
		rsp_d          = rsp_q;
		load           = 1'b0;
		job_pop        = 1'b0;
		drain_done     = 1'b0;
		sq_pop         = 1'b0;
		eq_pop         = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (job_valid && load_ok) begin
					load                         = 1'b1;
					job_pop                      = 1'b1;
					rsp_d.kind                   = job.kind;
					rsp_d.who                    = job.who;
					rsp_d.from_shared_queue      = 1'b0;
					rsp_d.last                   = (job.n_shared == '0) && (job.n_excl == '0);
					rsp_d.peak_shared_waiting    = job.peak_shared;
					rsp_d.peak_exclusive_waiting = job.peak_excl;
					rem_s_d                      = job.n_shared;
					rem_e_d                      = job.n_excl;
					shared_first_d               = job.shared_first;
					pk_s_d                       = job.peak_shared;
					pk_e_d                       = job.peak_excl;
					if (!rsp_d.last) begin
						state_d = BK_DRAIN;
					end
				end
			end
			BK_DRAIN: begin
				if (load_ok) begin
					load                         = 1'b1;
					rsp_d.kind                   = KIND_WOKEN;
					rsp_d.who                    = use_s ? sq_mem_q[sq_head_q] : eq_mem_q[eq_head_q];
					rsp_d.from_shared_queue      = use_s;
					rsp_d.last                   = (rem_total == (PEAK_W + 1)'(1));
					rsp_d.peak_shared_waiting    = pk_s_q;
					rsp_d.peak_exclusive_waiting = pk_e_q;
					sq_pop                       = use_s;
					eq_pop                       = !use_s;
					if (use_s) begin
						rem_s_d = rem_s_q - 1'b1;
					end else begin
						rem_e_d = rem_e_q - 1'b1;
					end
					if (rsp_d.last) begin
						drain_done = 1'b1;
						state_d    = BK_IDLE;
					end
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (qpush.valid && qpush.to_shared) begin
			sq_mem_q[sq_tail_q] <= qpush.id;
		end
		if (qpush.valid && !qpush.to_shared) begin
			eq_mem_q[eq_tail_q] <= qpush.id;
		end
		if (load) begin
			rsp_q <= rsp_d;
		end
		rem_s_q        <= rem_s_d;
		rem_e_q        <= rem_e_d;
		shared_first_q <= shared_first_d;
		pk_s_q         <= pk_s_d;
		pk_e_q         <= pk_e_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_head_q   <= '0;
			sq_tail_q   <= '0;
			eq_head_q   <= '0;
			eq_tail_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (qpush.valid && qpush.to_shared) begin
				sq_tail_q <= (sq_tail_q == PW'(QUEUE_DEPTH - 1)) ? '0 : sq_tail_q + 1'b1;
			end
			if (qpush.valid && !qpush.to_shared) begin
				eq_tail_q <= (eq_tail_q == PW'(QUEUE_DEPTH - 1)) ? '0 : eq_tail_q + 1'b1;
			end
			if (sq_pop) begin
				sq_head_q <= (sq_head_q == PW'(QUEUE_DEPTH - 1)) ? '0 : sq_head_q + 1'b1;
			end
			if (eq_pop) begin
				eq_head_q <= (eq_head_q == PW'(QUEUE_DEPTH - 1)) ? '0 : eq_head_q + 1'b1;
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTH
	// While draining there is always a waiter left to wake.
	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DRAIN) |-> (rem_total != '0))
		else $error("drain state with nothing to wake");

	// The end of a drain always presents a final result.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		drain_done |=> (rsp_valid_q && rsp_q.last))
		else $error("drain finished without a final result");

	// No queue write happens while a drain is running.
	a_no_push_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DRAIN) |-> !qpush.valid)
		else $error("queue written during drain");
`endif

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking testbench of the reader-writer lock manager
// Drives lock, shared-lock and unlock requests through the valid/stall request
// channel. Every accepted request is run through a local model of the lock.
// The model yields the responses that the request should cause, and each
// response taken from the block is compared field by field with the oldest
// one still outstanding.
// ============================================================================
module tb;
	import rwl_pkg::*;

	localparam int QUEUE_DEPTH  = 16;
	localparam int RANDOM_ITEMS = 110;
	// Cycles the receiver holds off in one go, long enough to back the block up.
	localparam int LONG_HOLD    = 100;
	// Quiet cycles after the last outstanding response, to catch strays.
	localparam int DRAIN_CYCLES = 20;
	// Command code that the block ignores; the package enum has no name for it.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// How a row of the directed script is checked.
	typedef enum logic [1:0] {
		CHK_MODEL,	// expected responses come from the lock model
		CHK_ONE,	// one response, typed into the row
		CHK_NONE	// the request causes no response at all
	} row_check_t;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [ID_W-1:0]   id;
		row_check_t        check;
		kind_t             kind;
		logic [PEAK_W-1:0] psh;
		logic [PEAK_W-1:0] pex;
	} script_row_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	// Local copy of the lock state, as it stands after the last accepted request.
	bit                lock_held = 1'b0;
	logic [ID_W-1:0]   lock_holder = '0;
	logic [RC_W-1:0]   reader_count = '0;
	logic [ID_W-1:0]   read_waiters[$];
	logic [ID_W-1:0]   excl_waiters[$];
	logic [PEAK_W-1:0] peak_shared = '0;
	logic [PEAK_W-1:0] peak_excl = '0;

	// Responses of the request being modeled, and all responses still owed.
	rsp_t step_results[$];
	rsp_t pending_results[$];

	int mismatch_count = 0;
	// Set by the request side; read (and the hold request cleared) by the receiver.
	bit quiet_tail = 1'b0;
	bit long_hold_req = 1'b0;

	reader_writer_lock_manager_top #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Append one response to those of the current request. The last flag and the
	// peaks are filled in once the whole request has been modeled.
	function automatic void note_result(input kind_t kind, input logic [ID_W-1:0] who,
			input logic from_shared);
		rsp_t r;
		r = '0;
		r.kind = kind;
		r.who = who;
		r.from_shared_queue = from_shared;
		step_results.push_back(r);
	endfunction

	// Wake every waiter, one response each, in the order the release calls for.
	function automatic void wake_waiters(input bit shared_first);
		if (shared_first) begin
			while (read_waiters.size() > 0)
				note_result(KIND_WOKEN, read_waiters.pop_front(), 1'b1);
		end
		while (excl_waiters.size() > 0)
			note_result(KIND_WOKEN, excl_waiters.pop_front(), 1'b0);
		while (read_waiters.size() > 0)
			note_result(KIND_WOKEN, read_waiters.pop_front(), 1'b1);
	endfunction

	// Lock model: apply one accepted request to the local state and leave the
	// responses it causes in step_results.
	function automatic void predict_lock_results(input req_t item);
		rsp_t r;
		step_results.delete();
		case (item.cmd)
			CMD_EXCL: begin
				if (!lock_held && reader_count == 0) begin
					lock_held = 1'b1;
					lock_holder = item.requester;
					note_result(KIND_GRANTED, item.requester, 1'b0);
				end else if (excl_waiters.size() < QUEUE_DEPTH) begin
					excl_waiters.push_back(item.requester);
					if (excl_waiters.size() > peak_excl)
						peak_excl = PEAK_W'(excl_waiters.size());
					note_result(KIND_QUEUED, item.requester, 1'b0);
				end else begin
					note_result(KIND_FULL, item.requester, 1'b0);
				end
			end
			CMD_SHARED: begin
				if (!lock_held) begin
					if (reader_count == READER_MAX) begin
						note_result(KIND_FULL, item.requester, 1'b0);
					end else begin
						reader_count++;
						note_result(KIND_GRANTED, item.requester, 1'b0);
					end
				end else if (read_waiters.size() < QUEUE_DEPTH) begin
					read_waiters.push_back(item.requester);
					if (read_waiters.size() > peak_shared)
						peak_shared = PEAK_W'(read_waiters.size());
					note_result(KIND_QUEUED, item.requester, 1'b0);
				end else begin
					note_result(KIND_FULL, item.requester, 1'b0);
				end
			end
			CMD_UNLOCK: begin
				if (reader_count == 0) begin
					if (!lock_held || lock_holder != item.requester) begin
						note_result(KIND_BAD, item.requester, 1'b0);
					end else begin
						lock_held = 1'b0;
						lock_holder = '0;
						note_result(KIND_RELEASED, item.requester, 1'b0);
						wake_waiters(1'b1);
					end
				end else begin
					// Readers are anonymous: anyone may drop one read hold.
					reader_count--;
					note_result(KIND_RELEASED, item.requester, 1'b0);
					wake_waiters(reader_count != 0);
				end
			end
			default: ;
		endcase
		foreach (step_results[k]) begin
			r = step_results[k];
			r.last = (k == step_results.size() - 1);
			r.peak_shared_waiting = peak_shared;
			r.peak_exclusive_waiting = peak_excl;
			step_results[k] = r;
		end
	endfunction

	// Offer one request and wait until the block takes it. Acceptance is seen at
	// the edge, so the model is updated in the same step as the block. With
	// use_model clear, the caller types in the expected response itself.
	task automatic send_request(input logic [1:0] cmd, input logic [ID_W-1:0] id,
			input bit use_model);
		req_t item;
		item.cmd = cmd_t'(cmd);
		item.requester = id;
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		predict_lock_results(item);
		if (use_model) begin
			foreach (step_results[k])
				pending_results.push_back(step_results[k]);
		end
	endtask

	// Drop valid for a burst of idle cycles. The callers always ask for a nonzero
	// pause, so valid is never lowered and raised again in the same step.
	task automatic pause_sender(input int cycles);
		req_valid <= 1'b0;
		repeat (cycles)
			@(posedge clk);
	endtask

	// Drop valid and wait until every owed response has come back.
	task automatic hold_until_drained();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	task automatic check_field(input string field, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", field, want, got);
			mismatch_count++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Request side: reset, directed script, random episodes, then a short tail
	// of requests with both sides running flat out.
	// ------------------------------------------------------------------------
	initial begin : request_side
		script_row_t script [0:16];
		rsp_t typed;
		logic [1:0] cmd;
		logic [ID_W-1:0] id;
		int sent;
		int ep_left;
		int unlock_pct;
		int gap_pct;
		int r;
		bit first_episode;
		bit open_with_excl;

		// The typed rows are the ones whose response is plain from the state:
		// unlocks with nothing held or by a stranger, the ignored command, and
		// the grants of a free lock.
		script = '{
			'{CMD_UNLOCK, 8'd0,   CHK_ONE,   KIND_BAD,     5'd0, 5'd0},
			'{CMD_UNUSED, 8'd255, CHK_NONE,  KIND_GRANTED, 5'd0, 5'd0},
			'{CMD_EXCL,   8'd255, CHK_ONE,   KIND_GRANTED, 5'd0, 5'd0},
			'{CMD_UNLOCK, 8'd0,   CHK_ONE,   KIND_BAD,     5'd0, 5'd0},
			'{CMD_SHARED, 8'd0,   CHK_MODEL, KIND_GRANTED, 5'd0, 5'd0},
			'{CMD_EXCL,   8'd1,   CHK_MODEL, KIND_GRANTED, 5'd0, 5'd0},
			'{CMD_SHARED, 8'd128, CHK_MODEL, KIND_GRANTED, 5'd0, 5'd0},
			'{CMD_EXCL,   8'd170, CHK_MODEL, KIND_GRANTED, 5'd0, 5'd0},
			// Exclusive release: shared waiters are woken ahead of exclusive ones.
			'{CMD_UNLOCK, 8'd255, CHK_MODEL, KIND_GRANTED, 5'd0, 5'd0},
			'{CMD_SHARED, 8'd255, CHK_MODEL, KIND_GRANTED, 5'd0, 5'd0},
			'{CMD_SHARED, 8'd85,  CHK_MODEL, KIND_GRANTED, 5'd0, 5'd0},
			'{CMD_EXCL,   8'd20,  CHK_MODEL, KIND_GRANTED, 5'd0, 5'd0},
			// A stranger drops a read hold while another reader stays.
			'{CMD_UNLOCK, 8'd99,  CHK_MODEL, KIND_GRANTED, 5'd0, 5'd0},
			'{CMD_EXCL,   8'd21,  CHK_MODEL, KIND_GRANTED, 5'd0, 5'd0},
			// The last reader leaves, so exclusive waiters go first.
			'{CMD_UNLOCK, 8'd7,   CHK_MODEL, KIND_GRANTED, 5'd0, 5'd0},
			'{CMD_EXCL,   8'd0,   CHK_ONE,   KIND_GRANTED, 5'd2, 5'd2},
			'{CMD_UNLOCK, 8'd0,   CHK_MODEL, KIND_GRANTED, 5'd0, 5'd0}
		};

		req_valid = 1'b0;
		req = '0;
		arst_n = 1'b0;
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			send_request(script[i].cmd, script[i].id, script[i].check == CHK_MODEL);
			if (script[i].check == CHK_ONE) begin
				typed = '0;
				typed.kind = script[i].kind;
				typed.who = script[i].id;
				typed.last = 1'b1;
				typed.peak_shared_waiting = script[i].psh;
				typed.peak_exclusive_waiting = script[i].pex;
				pending_results.push_back(typed);
			end
		end
		// The sender sits still until the directed part has fully come back.
		hold_until_drained();

		// Random part in episodes, each with its own unlock rate and gap rate.
		// The first one opens with an exclusive grant on the free lock and never
		// unlocks, so both wait queues run full and overflow.
		sent = 0;
		ep_left = 0;
		first_episode = 1'b1;
		open_with_excl = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			if (ep_left == 0) begin
				ep_left = first_episode ? 40 : $urandom_range(8, 30);
				unlock_pct = first_episode ? 0 : $urandom_range(3, 45);
				case ($urandom_range(0, 2))
					0: gap_pct = 0;
					1: gap_pct = 10;
					default: gap_pct = 30;
				endcase
				open_with_excl = first_episode;
				first_episode = 1'b0;
			end
			ep_left--;

			id = ID_W'($urandom_range(0, 255));
			r = $urandom_range(0, 99);
			if (open_with_excl) begin
				cmd = CMD_EXCL;
				open_with_excl = 1'b0;
			end else if (r < 4) begin
				cmd = CMD_UNUSED;
			end else if (r < 4 + unlock_pct) begin
				// Mostly a proper release by the holder; now and then a stranger.
				cmd = CMD_UNLOCK;
				if (lock_held && $urandom_range(0, 9) != 0)
					id = lock_holder;
			end else begin
				cmd = ($urandom_range(0, 1) != 0) ? CMD_EXCL : CMD_SHARED;
			end

			send_request(cmd, id, 1'b1);
			if (cmd != CMD_UNUSED) begin
				sent++;
				// Ask the receiver for a long hold-off while requests keep coming.
				if (sent == 40)
					long_hold_req = 1'b1;
			end
			if (sent == 90 && cmd != CMD_UNUSED)
				hold_until_drained();
			else if ($urandom_range(0, 99) < gap_pct)
				pause_sender($urandom_range(1, 18));
		end

		// Tail of the run: no idling on either side. Free the exclusive hold, then
		// a few back-to-back requests on the freed lock.
		quiet_tail = 1'b1;
		if (lock_held)
			send_request(CMD_UNLOCK, lock_holder, 1'b1);
		send_request(CMD_SHARED, 8'd255, 1'b1);
		send_request(CMD_EXCL, 8'd3, 1'b1);
		send_request(CMD_UNLOCK, 8'd4, 1'b1);
		send_request(CMD_SHARED, 8'd5, 1'b1);
		send_request(CMD_SHARED, 8'd0, 1'b1);

		hold_until_drained();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Response side stall: random stall bursts, calm stretches with no stall at all,
	// and one long hold-off counted here when asked for. The next value is worked
	// out first so rsp_stall gets one assignment per edge.
	// ------------------------------------------------------------------------
	initial begin : receiver
		int hold_left;
		int burst_left;
		int calm_left;
		int r;
		bit stall_next;

		hold_left = 0;
		burst_left = 0;
		calm_left = 0;
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD - 1;
				stall_next = 1'b1;
			end else if (quiet_tail) begin
				stall_next = 1'b0;
			end else if (burst_left > 0) begin
				burst_left--;
				stall_next = 1'b1;
			end else if (calm_left > 0) begin
				calm_left--;
				stall_next = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 8) begin
					burst_left = $urandom_range(1, 18) - 1;
					stall_next = 1'b1;
				end else begin
					if (r < 11)
						calm_left = $urandom_range(20, 60);
					stall_next = 1'b0;
				end
			end
			rsp_stall <= stall_next;
		end
	end

	// ------------------------------------------------------------------------
	// Response check: each response taken at an edge is matched against the
	// oldest owed one. A response nobody is waiting for is a failure too.
	// ------------------------------------------------------------------------
	initial begin : result_check
		rsp_t want;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall) begin
				if (pending_results.size() == 0) begin
					$error("unexpected response: kind %0d, who %0d", rsp.kind, rsp.who);
					mismatch_count++;
				end else begin
					want = pending_results.pop_front();
					check_field("kind", want.kind, rsp.kind);
					check_field("who", want.who, rsp.who);
					check_field("from_shared_queue", want.from_shared_queue,
						rsp.from_shared_queue);
					check_field("last", want.last, rsp.last);
					check_field("peak_shared_waiting", want.peak_shared_waiting,
						rsp.peak_shared_waiting);
					check_field("peak_exclusive_waiting", want.peak_exclusive_waiting,
						rsp.peak_exclusive_waiting);
				end
			end
		end
	end

	// Hard stop, many times beyond the slowest correct run.
	initial begin : run_limit
		#4_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
